>>> hw/rtl/can_tx_slot_queue_macros.svh
// Assertion macros shared by the transmit slot queue RTL.
// Depends on nothing; users must provide clk and rst_n in scope.
`ifndef CAN_TX_SLOT_QUEUE_MACROS_SVH
`define CAN_TX_SLOT_QUEUE_MACROS_SVH

// same-cycle implication, disabled in reset
`define CTSQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define CTSQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/ctsq_pkg.sv
// Shared types and constants for the CAN transmit slot queue.
// No dependencies; used by ctsq_ctrl, ctsq_dp and can_tx_slot_queue.
`default_nettype none

package ctsq_pkg;

    // sizing
    localparam int SLOTS_DEF  = 32;
    localparam int CHUNK      = 8;
    localparam int CHUNK_W    = 3;
    localparam int ID_W       = 11;
    localparam int LEN_W      = 4;
    localparam int DATA_W     = 64;
    localparam int CNT_W      = 8;
    localparam int CFG_W      = 6;
    localparam int META_W     = ID_W + 1 + LEN_W;

    localparam logic [CFG_W-1:0] SLOT_COUNT_RST = 6'd32;
    localparam logic [LEN_W-1:0] MAX_LEN        = 4'd8;
    localparam logic [CNT_W-1:0] COUNT_MAX      = 8'hFF;

    // request kinds
    typedef enum logic [1:0] {
        MODE_SETUP = 2'd0,
        MODE_SEND  = 2'd1,
        MODE_DONE  = 2'd2,
        MODE_CLEAR = 2'd3
    } mode_t;

    // status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
    localparam logic [1:0] STATUS_ILLEGAL  = 2'd2;

    // sync drop codes
    localparam logic [1:0] DROP_NONE    = 2'd0;
    localparam logic [1:0] DROP_MODULE  = 2'd1;
    localparam logic [1:0] DROP_WAITING = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic scan;
        logic load;
        logic finish;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic go_scan;
        logic go_load;
        logic scan_hit;
        logic scan_last;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/can_tx_slot_queue.sv
// Top level of the CAN transmit slot queue: controller plus datapath.
// Depends on ctsq_pkg, ctsq_ctrl and ctsq_dp.
//
//   channel  | handshake              | beat carries
//   ---------+------------------------+------------------------------------------
//   in       | in_valid / in_ready    | mode, slot_index, frame_id, ..., send_data
//   out      | out_valid / out_ready  | status, overflow_report, frame_valid, ...
//   cfg      | cfg_valid / cfg_ready  | cfg_slot_count
//
// An item passes through capture, execute and finish; a direct send adds a
// load step, and transmit done / clear sync with a pending count add a scan of
// up to ceil(SLOTS/8) chunks (and a load on a done hit): the scan unit walks 8 slot flags per cycle.
// Reset is asynchronous, active low; no clearing pass, the block is ready at once.
// The result sits in an output register; a stalled output only holds the
// item in its final cycle, so the next beat is taken once it moves on.
`default_nettype none

module can_tx_slot_queue
#(
    parameter int SLOTS = ctsq_pkg::SLOTS_DEF
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // item channel
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [1:0]                     mode,
    input  wire logic [7:0]                     slot_index,
    input  wire logic [ctsq_pkg::ID_W-1:0]      frame_id,
    input  wire logic                           remote_request,
    input  wire logic [ctsq_pkg::LEN_W-1:0]     byte_count,
    input  wire logic                           sync_flag,
    input  wire logic [ctsq_pkg::DATA_W-1:0]    send_data,
    // result channel
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [1:0]                          status,
    output logic                                overflow_report,
    output logic                                frame_valid,
    output logic [ctsq_pkg::ID_W-1:0]           out_id,
    output logic                                out_rtr,
    output logic [ctsq_pkg::LEN_W-1:0]          out_length,
    output logic [ctsq_pkg::DATA_W-1:0]         out_data,
    output logic                                abort_request,
    output logic [1:0]                          sync_dropped,
    // configuration channel
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [ctsq_pkg::CFG_W-1:0]     cfg_slot_count
);

    ctsq_pkg::cmd_t  cmd;
    ctsq_pkg::stat_t st;

    ctsq_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    ctsq_dp
    #(
        .SLOTS (SLOTS)
    )
    u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .st              (st),
        .mode            (mode),
        .slot_index      (slot_index),
        .frame_id        (frame_id),
        .remote_request  (remote_request),
        .byte_count      (byte_count),
        .sync_flag       (sync_flag),
        .send_data       (send_data),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_slot_count  (cfg_slot_count),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .overflow_report (overflow_report),
        .frame_valid     (frame_valid),
        .out_id          (out_id),
        .out_rtr         (out_rtr),
        .out_length      (out_length),
        .out_data        (out_data),
        .abort_request   (abort_request),
        .sync_dropped    (sync_dropped)
    );

endmodule

`default_nettype wire

>>> hw/rtl/ctsq_ctrl.sv
// Sequencing state machine for the CAN transmit slot queue.
// Depends on ctsq_pkg and can_tx_slot_queue_macros.svh.
`default_nettype none
`include "can_tx_slot_queue_macros.svh"

module ctsq_ctrl
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  ctsq_pkg::stat_t     st,
    output ctsq_pkg::cmd_t      cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_EXEC   = 5'b00010,
        S_SCAN   = 5'b00100,
        S_LOAD   = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                priority if (st.go_scan)
                begin
                    state_next = S_SCAN;
                end
                else if (st.go_load)
                begin
                    state_next = S_LOAD;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_SCAN:
            begin
                priority if (st.scan_hit)
                begin
                    state_next = S_LOAD;
                end
                else if (st.scan_last)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_LOAD:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (st.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // commands
    assign in_ready    = (state_reg == S_IDLE);
    assign cmd.capture = (state_reg == S_IDLE) && in_valid;
    assign cmd.exec    = (state_reg == S_EXEC);
    assign cmd.scan    = (state_reg == S_SCAN);
    assign cmd.load    = (state_reg == S_LOAD);
    assign cmd.finish  = (state_reg == S_FINISH) && st.out_free;

    // checks
    `CTSQ_ASSERT_NEXT(a_one_beat_per_item, in_valid && in_ready, !in_ready, "second beat taken while busy")
    `CTSQ_ASSERT_NEXT(a_idle_exit, state_reg == S_IDLE, state_reg == S_IDLE || state_reg == S_EXEC, "bad exit from idle")
    `CTSQ_ASSERT_NEXT(a_finish_hold, state_reg == S_FINISH && !st.out_free, state_reg == S_FINISH, "result dropped on full output")

endmodule

`default_nettype wire

>>> hw/rtl/ctsq_dp.sv
// Datapath of the CAN transmit slot queue: slot flags, slot memories,
// pending count, chunked scan unit and output register. Depends on ctsq_pkg
// and can_tx_slot_queue_macros.svh.
`default_nettype none
`include "can_tx_slot_queue_macros.svh"

module ctsq_dp
#(
    parameter int SLOTS = ctsq_pkg::SLOTS_DEF
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  ctsq_pkg::cmd_t                      cmd,
    output ctsq_pkg::stat_t                     st,
    // item beat
    input  wire logic [1:0]                     mode,
    input  wire logic [7:0]                     slot_index,
    input  wire logic [ctsq_pkg::ID_W-1:0]      frame_id,
    input  wire logic                           remote_request,
    input  wire logic [ctsq_pkg::LEN_W-1:0]     byte_count,
    input  wire logic                           sync_flag,
    input  wire logic [ctsq_pkg::DATA_W-1:0]    send_data,
    // configuration
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [ctsq_pkg::CFG_W-1:0]     cfg_slot_count,
    // result
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [1:0]                          status,
    output logic                                overflow_report,
    output logic                                frame_valid,
    output logic [ctsq_pkg::ID_W-1:0]           out_id,
    output logic                                out_rtr,
    output logic [ctsq_pkg::LEN_W-1:0]          out_length,
    output logic [ctsq_pkg::DATA_W-1:0]         out_data,
    output logic                                abort_request,
    output logic [1:0]                          sync_dropped
);

    localparam int NCHUNK = (SLOTS + ctsq_pkg::CHUNK - 1) / ctsq_pkg::CHUNK;
    localparam int PAD    = NCHUNK * ctsq_pkg::CHUNK;
    localparam int CW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int SIW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CK     = ctsq_pkg::CHUNK;
    localparam int CKW    = ctsq_pkg::CHUNK_W;
    localparam int IW     = ctsq_pkg::ID_W;
    localparam int LW     = ctsq_pkg::LEN_W;
    localparam int DW     = ctsq_pkg::DATA_W;
    localparam int MW     = ctsq_pkg::META_W;
    localparam int NW     = 9;

    function automatic logic [CKW:0] popcnt(input logic [CK-1:0] v);
        logic [CKW:0] c;
        c = '0;
        for (int k = 0; k < CK; k++)
        begin
            c = c + (CKW+1)'(v[k]);
        end
        return c;
    endfunction

    // control state
    logic [SLOTS-1:0]                 full_reg, full_next;
    logic [SLOTS-1:0]                 sync_reg, sync_next;
    logic [SLOTS-1:0]                 mvalid_reg, mvalid_next;
    logic [ctsq_pkg::CNT_W-1:0]       count_reg, count_next;
    logic                             first_reg, first_next;
    logic                             sim_reg, sim_next;
    logic                             busy_reg, busy_next;
    logic [ctsq_pkg::CFG_W-1:0]       slot_count_reg, slot_count_next;
    logic [CW-1:0]                    chunk_reg, chunk_next;
    logic                             out_valid_reg, out_valid_next;

    // item and result registers
    ctsq_pkg::mode_t                  mode_reg;
    logic [7:0]                       idx_reg;
    logic [IW-1:0]                    id_reg;
    logic                             rtr_reg;
    logic [LW-1:0]                    len_reg;
    logic                             sflag_reg;
    logic [DW-1:0]                    data_reg;
    logic [SIW-1:0]                   load_idx_reg, load_idx_next;
    logic [1:0]                       res_status_reg, res_status_next;
    logic                             res_ovf_reg, res_ovf_next;
    logic                             res_frame_reg, res_frame_next;
    logic [IW-1:0]                    res_id_reg, res_id_next;
    logic                             res_rtr_reg, res_rtr_next;
    logic [LW-1:0]                    res_len_reg, res_len_next;
    logic [DW-1:0]                    res_data_reg, res_data_next;
    logic                             res_abort_reg, res_abort_next;
    logic [1:0]                       res_drop_reg, res_drop_next;
    logic [1:0]                       out_status_reg;
    logic                             out_ovf_reg;
    logic                             out_frame_reg;
    logic [IW-1:0]                    out_id_reg;
    logic                             out_rtr_reg;
    logic [LW-1:0]                    out_len_reg;
    logic [DW-1:0]                    out_data_reg;
    logic                             out_abort_reg;
    logic [1:0]                       out_drop_reg;

    // slot memories
    logic [MW-1:0]                    meta_mem [SLOTS];
    logic [DW-1:0]                    pay_mem  [SLOTS];
    logic [MW-1:0]                    meta_rd_reg;
    logic [DW-1:0]                    pay_rd_reg;

    // decode
    logic [NW-1:0]                    n_use;
    logic                             legal;
    logic                             direct;
    logic [SIW-1:0]                   aidx;
    logic                             is_setup, is_send, is_done, is_clear;

    // scan unit
    logic [PAD-1:0]                   full_pad, sync_pad;
    logic [CK-1:0]                    full_ck, sync_ck, inuse_ck, cand;
    logic [CK-1:0]                    first_hot, sweep, clr;
    logic [CKW-1:0]                   enc;
    logic [CW+CKW-1:0]                found_full;
    logic [SIW-1:0]                   found;
    logic [CKW:0]                     pc;

    // memory access
    logic                             mem_rd;
    logic [SIW-1:0]                   rd_addr;

    // load formatting
    logic [MW-1:0]                    meta_eff;
    logic [LW-1:0]                    len_clamped;
    logic [DW-1:0]                    pay_src;
    logic [DW-1:0]                    pay_masked;

    assign cfg_ready = 1'b1;

    // item decode
    always_comb
    begin
        n_use = ({3'b000, slot_count_reg} > NW'(SLOTS)) ? NW'(SLOTS)
                                                         : {3'b000, slot_count_reg};
        is_setup = (mode_reg == ctsq_pkg::MODE_SETUP);
        is_send  = (mode_reg == ctsq_pkg::MODE_SEND);
        is_done  = (mode_reg == ctsq_pkg::MODE_DONE);
        is_clear = (mode_reg == ctsq_pkg::MODE_CLEAR);
        legal    = ({1'b0, idx_reg} < n_use);
        direct   = !busy_reg && (count_reg == '0);
        aidx     = idx_reg[SIW-1:0];
    end

    // one chunk of slot flags per cycle
    always_comb
    begin
        full_pad = '0;
        sync_pad = '0;
        full_pad[SLOTS-1:0] = full_reg;
        sync_pad[SLOTS-1:0] = sync_reg;
        full_ck = full_pad[{chunk_reg, CKW'(0)} +: CK];
        sync_ck = sync_pad[{chunk_reg, CKW'(0)} +: CK];
        for (int j = 0; j < CK; j++)
        begin
            inuse_ck[j] = (10'({chunk_reg, CKW'(j)}) < 10'(n_use));
        end
        cand      = full_ck & inuse_ck;
        first_hot = cand & (~cand + CK'(1));
        sweep     = cand & sync_ck;
        enc       = '0;
        for (int j = CK - 1; j >= 0; j--)
        begin
            if (cand[j])
            begin
                enc = CKW'(j);
            end
        end
        found_full = {chunk_reg, enc};
        found      = found_full[SIW-1:0];
        clr        = is_done ? first_hot : sweep;
        pc         = popcnt(sweep);
    end

    // status to controller
    assign st.go_scan   = (is_done || is_clear) && (count_reg != '0);
    assign st.go_load   = is_send && legal && direct;
    assign st.scan_hit  = is_done && (|cand);
    assign st.scan_last = (chunk_reg == CW'(NCHUNK - 1));
    assign st.out_free  = !out_valid_reg || out_ready;

    // frame formatting for the hardware buffer
    always_comb
    begin
        meta_eff    = mvalid_reg[load_idx_reg] ? meta_rd_reg : '0;
        len_clamped = (meta_eff[LW-1:0] > ctsq_pkg::MAX_LEN) ? ctsq_pkg::MAX_LEN
                                                              : meta_eff[LW-1:0];
        pay_src     = is_send ? data_reg : pay_rd_reg;
        for (int b = 0; b < 8; b++)
        begin
            pay_masked[b*8 +: 8] = (LW'(b) < len_clamped) ? pay_src[b*8 +: 8] : 8'h00;
        end
    end

    // next state of slot flags, counters and result
    always_comb
    begin
        full_next       = full_reg;
        sync_next       = sync_reg;
        mvalid_next     = mvalid_reg;
        count_next      = count_reg;
        first_next      = first_reg;
        sim_next        = sim_reg;
        busy_next       = busy_reg;
        slot_count_next = slot_count_reg;
        chunk_next      = chunk_reg;
        out_valid_next  = out_valid_reg;
        load_idx_next   = load_idx_reg;
        res_status_next = res_status_reg;
        res_ovf_next    = res_ovf_reg;
        res_frame_next  = res_frame_reg;
        res_id_next     = res_id_reg;
        res_rtr_next    = res_rtr_reg;
        res_len_next    = res_len_reg;
        res_data_next   = res_data_reg;
        res_abort_next  = res_abort_reg;
        res_drop_next   = res_drop_reg;

        if (cfg_valid)
        begin
            slot_count_next = cfg_slot_count;
        end

        // new item: clear result
        if (cmd.capture)
        begin
            chunk_next      = '0;
            res_status_next = ctsq_pkg::STATUS_OK;
            res_ovf_next    = 1'b0;
            res_frame_next  = 1'b0;
            res_id_next     = '0;
            res_rtr_next    = 1'b0;
            res_len_next    = '0;
            res_data_next   = '0;
            res_abort_next  = 1'b0;
            res_drop_next   = ctsq_pkg::DROP_NONE;
        end

        // first step of an item
        if (cmd.exec)
        begin
            unique case (mode_reg)
                ctsq_pkg::MODE_SETUP:
                begin
                    if (!legal)
                    begin
                        res_status_next = ctsq_pkg::STATUS_ILLEGAL;
                    end
                    else
                    begin
                        full_next[aidx]   = 1'b0;
                        sync_next[aidx]   = sflag_reg;
                        mvalid_next[aidx] = 1'b1;
                    end
                end
                ctsq_pkg::MODE_SEND:
                begin
                    if (!legal)
                    begin
                        res_status_next = ctsq_pkg::STATUS_ILLEGAL;
                    end
                    else
                    begin
                        if (full_reg[aidx])
                        begin
                            res_status_next = ctsq_pkg::STATUS_OVERFLOW;
                            res_ovf_next    = !first_reg;
                        end
                        if (direct)
                        begin
                            load_idx_next = aidx;
                        end
                        else
                        begin
                            full_next[aidx] = 1'b1;
                            if (count_reg != ctsq_pkg::COUNT_MAX)
                            begin
                                count_next = count_reg + 8'd1;
                            end
                        end
                    end
                end
                ctsq_pkg::MODE_DONE:
                begin
                    first_next = 1'b0;
                    sim_next   = 1'b0;
                    busy_next  = 1'b0;
                end
                ctsq_pkg::MODE_CLEAR:
                begin
                    if (sim_reg)
                    begin
                        sim_next       = 1'b0;
                        busy_next      = 1'b0;
                        res_abort_next = 1'b1;
                        res_drop_next  = ctsq_pkg::DROP_MODULE;
                    end
                end
                default:
                begin
                    res_status_next = ctsq_pkg::STATUS_OK;
                end
            endcase
        end

        // scan step over one chunk
        if (cmd.scan)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                if ((chunk_reg == CW'(i >> CKW)) && clr[i % CK])
                begin
                    full_next[i] = 1'b0;
                end
            end
            if (is_done)
            begin
                if (|cand)
                begin
                    count_next    = count_reg - 8'd1;
                    load_idx_next = found;
                end
                else if (st.scan_last)
                begin
                    count_next = '0;
                end
            end
            else
            begin
                count_next = (count_reg > 8'(pc)) ? (count_reg - 8'(pc)) : '0;
                if (|sweep)
                begin
                    res_drop_next = ctsq_pkg::DROP_WAITING;
                end
            end
            if (!st.scan_last)
            begin
                chunk_next = chunk_reg + CW'(1);
            end
        end

        // load frame into the hardware buffer
        if (cmd.load)
        begin
            res_frame_next = 1'b1;
            res_id_next    = meta_eff[MW-1 -: IW];
            res_rtr_next   = meta_eff[LW];
            res_len_next   = len_clamped;
            res_data_next  = pay_masked;
            sim_next       = sync_reg[load_idx_reg];
            busy_next      = 1'b1;
        end

        // output register
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg       <= '0;
            sync_reg       <= '0;
            mvalid_reg     <= '0;
            count_reg      <= '0;
            first_reg      <= 1'b1;
            sim_reg        <= 1'b0;
            busy_reg       <= 1'b0;
            slot_count_reg <= ctsq_pkg::SLOT_COUNT_RST;
            chunk_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            full_reg       <= full_next;
            sync_reg       <= sync_next;
            mvalid_reg     <= mvalid_next;
            count_reg      <= count_next;
            first_reg      <= first_next;
            sim_reg        <= sim_next;
            busy_reg       <= busy_next;
            slot_count_reg <= slot_count_next;
            chunk_reg      <= chunk_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // item, result and output payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg  <= ctsq_pkg::mode_t'(mode);
            idx_reg   <= slot_index;
            id_reg    <= frame_id;
            rtr_reg   <= remote_request;
            len_reg   <= byte_count;
            sflag_reg <= sync_flag;
            data_reg  <= send_data;
        end
        load_idx_reg   <= load_idx_next;
        res_status_reg <= res_status_next;
        res_ovf_reg    <= res_ovf_next;
        res_frame_reg  <= res_frame_next;
        res_id_reg     <= res_id_next;
        res_rtr_reg    <= res_rtr_next;
        res_len_reg    <= res_len_next;
        res_data_reg   <= res_data_next;
        res_abort_reg  <= res_abort_next;
        res_drop_reg   <= res_drop_next;
        if (cmd.finish)
        begin
            out_status_reg <= res_status_reg;
            out_ovf_reg    <= res_ovf_reg;
            out_frame_reg  <= res_frame_reg;
            out_id_reg     <= res_id_reg;
            out_rtr_reg    <= res_rtr_reg;
            out_len_reg    <= res_len_reg;
            out_data_reg   <= res_data_reg;
            out_abort_reg  <= res_abort_reg;
            out_drop_reg   <= res_drop_reg;
        end
    end

    // slot memories: one write and one registered read each
    assign mem_rd  = (cmd.exec && st.go_load) || (cmd.scan && st.scan_hit);
    assign rd_addr = cmd.exec ? aidx : found;

    always_ff @(posedge clk)
    begin
        if (cmd.exec && is_setup && legal)
        begin
            meta_mem[aidx] <= {id_reg, rtr_reg, len_reg};
        end
        if (mem_rd)
        begin
            meta_rd_reg <= meta_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && is_send && legal)
        begin
            pay_mem[aidx] <= data_reg;
        end
        if (mem_rd)
        begin
            pay_rd_reg <= pay_mem[rd_addr];
        end
    end

    // ports
    assign out_valid       = out_valid_reg;
    assign status          = out_status_reg;
    assign overflow_report = out_ovf_reg;
    assign frame_valid     = out_frame_reg;
    assign out_id          = out_id_reg;
    assign out_rtr         = out_rtr_reg;
    assign out_length      = out_len_reg;
    assign out_data        = out_data_reg;
    assign abort_request   = out_abort_reg;
    assign sync_dropped    = out_drop_reg;

    // checks
    `CTSQ_ASSERT_NOW(a_len_clamped, out_valid_reg, out_len_reg <= ctsq_pkg::MAX_LEN, "length above eight")
    `CTSQ_ASSERT_NOW(a_frame_legal, out_valid_reg && out_frame_reg, out_status_reg != ctsq_pkg::STATUS_ILLEGAL, "frame on illegal slot")
    `CTSQ_ASSERT_NEXT(a_hit_decrements, cmd.scan && st.scan_hit, count_reg == $past(count_reg) - 8'd1, "scan hit without count step")
    `CTSQ_ASSERT_NEXT(a_load_busy, cmd.load, busy_reg, "load left buffer idle")

endmodule

`default_nettype wire
